// ===== rtl/imu_bcs_pkg.sv =====
// Shared types and constants for the IMU bias calibrate/subtract block.
// Standalone package; imported by imu_bcs_div, imu_bcs_cal and the top level.
package imu_bcs_pkg;

  localparam int AXES    = 3;
  localparam int WORD_W  = 16;
  localparam int ONE_G_W = 15;
  // corrected word widened by one bit so one g can be removed without overflow
  localparam int VAL_W   = WORD_W + 1;

  localparam logic [ONE_G_W-1:0] ONE_G_RESET = 15'd8196;

  // axis order inside a triad
  localparam int AX_X = 0;
  localparam int AX_Y = 1;
  localparam int AX_Z = 2;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [AXES-1:0][WORD_W-1:0] triad_t;

  typedef struct packed {
    word_t accel_x_raw;
    word_t accel_y_raw;
    word_t accel_z_raw;
    word_t gyro_x_raw;
    word_t gyro_y_raw;
    word_t gyro_z_raw;
    logic  request_gyro_cal;
    logic  request_accel_cal;
  } in_item_t;

  typedef struct packed {
    word_t accel_x_out;
    word_t accel_y_out;
    word_t accel_z_out;
    word_t gyro_x_out;
    word_t gyro_y_out;
    word_t gyro_z_out;
    logic  gyro_cal_active;
    logic  accel_cal_active;
  } out_item_t;

  typedef struct packed {
    logic [ONE_G_W-1:0] accel_one_g;
  } cfg_item_t;

  // calibration requests handed to the calibration unit with each sample
  typedef struct packed {
    logic fire;
    logic gyro;
    logic accel;
  } cal_req_t;

  // calibration flags after the sample being processed
  typedef struct packed {
    logic gyro_cal_active;
    logic accel_cal_active;
  } cal_status_t;

  // registered view of the calibration state
  typedef struct packed {
    logic gyro_run;
    logic accel_run;
    logic count_zero;
    logic count_ok;
  } cal_view_t;

endpackage

// ===== rtl/imu_bcs_chan_if.sv =====
// Valid/ready channel interface used for the sample, result and config ports.
// Payload type is a parameter; no package dependency.
interface imu_bcs_chan_if #(parameter type payload_t = logic);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// ===== rtl/imu_bcs_div.sv =====
// Signed divide by the constant CAL_SAMPLES, truncating toward zero,
// by reciprocal multiply on the magnitude. Uses imu_bcs_pkg.
module imu_bcs_div
  import imu_bcs_pkg::*;
#(
  parameter int CAL_SAMPLES = 200,
  parameter int SUM_W       = 25
) (
  input  logic signed [SUM_W-1:0]  sum_i,
  output logic        [WORD_W-1:0] quot_o
);

  localparam int MAG_W   = SUM_W - 1;
  localparam int SHIFT   = MAG_W + $clog2(CAL_SAMPLES);
  localparam int RECIP_W = MAG_W + 1;
  localparam int PROD_W  = MAG_W + RECIP_W;
  localparam logic [63:0] RECIP =
    ((64'd1 << SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);

  logic              neg;
  logic [MAG_W-1:0]  mag;
  logic [PROD_W-1:0] prod;
  logic [MAG_W-1:0]  q_mag;
  logic [MAG_W-1:0]  q_sgn;

  // take magnitude, scale by reciprocal, restore sign, wrap to one word
  always_comb begin
    neg    = sum_i[SUM_W-1];
    mag    = neg ? MAG_W'(-sum_i) : MAG_W'(sum_i);
    prod   = PROD_W'(mag) * PROD_W'(RECIP[RECIP_W-1:0]);
    q_mag  = MAG_W'(prod >> SHIFT);
    q_sgn  = neg ? (MAG_W'(0) - q_mag) : q_mag;
    quot_o = q_sgn[WORD_W-1:0];
  end

endmodule

// ===== rtl/imu_bcs_cal.sv =====
// Calibration unit: offset registers, shared axis sums, sample counter and
// run flags. Uses imu_bcs_pkg and imu_bcs_div.
module imu_bcs_cal
  import imu_bcs_pkg::*;
#(
  parameter int CAL_SAMPLES = 200
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cal_req_t           req_i,
  input  triad_t             acc_i,
  input  triad_t             gyr_i,
  input  logic [ONE_G_W-1:0] one_g_i,
  output triad_t             accel_off_o,
  output triad_t             gyro_off_o,
  output cal_status_t        status_o,
  output cal_view_t          view_o
);

  localparam int SUM_W = VAL_W + $clog2(CAL_SAMPLES);
  localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
  localparam logic [CNT_W-1:0] CNT_FIRST = CNT_W'(2);
  localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(CAL_SAMPLES);

  triad_t                  gyro_off_r, gyro_off_nxt;
  triad_t                  accel_off_r, accel_off_nxt;
  logic signed [SUM_W-1:0] sum_r   [AXES];
  logic signed [SUM_W-1:0] sum_nxt [AXES];
  logic signed [SUM_W-1:0] sum_add [AXES];
  logic signed [VAL_W-1:0] val     [AXES];
  triad_t                  quot;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt, cnt_a;
  logic                    gflag_r, gflag_nxt, gflag_a;
  logic                    aflag_r, aflag_nxt, aflag_a;
  logic                    start, done;

  // one divider per axis, fed with the updated sum
  for (genvar g = 0; g < AXES; g++) begin : g_div
    imu_bcs_div #(
      .CAL_SAMPLES (CAL_SAMPLES),
      .SUM_W       (SUM_W)
    ) u_div (
      .sum_i  (sum_add[g]),
      .quot_o (quot[g])
    );
  end

  // latch requests, pick the running sensor, form the updated sums
  always_comb begin
    gflag_a = gflag_r | req_i.gyro;
    aflag_a = aflag_r | req_i.accel;
    // a gyro request abandons a running accel pass
    cnt_a   = (req_i.gyro && !gflag_r && aflag_r) ? '0 : cnt_r;
    for (int i = 0; i < AXES; i++) begin
      val[i] = gflag_a ? VAL_W'($signed(gyr_i[i])) : VAL_W'($signed(acc_i[i]));
    end
    if (!gflag_a) begin
      val[AX_Z] = VAL_W'($signed(acc_i[AX_Z])) - VAL_W'(one_g_i);
    end
    start = (cnt_a == '0);
    done  = !start && (cnt_a >= CNT_LAST);
    for (int i = 0; i < AXES; i++) begin
      sum_add[i] = sum_r[i] + SUM_W'(val[i]);
    end
  end

  // advance the calibration state for one sample
  always_comb begin
    gyro_off_nxt  = gyro_off_r;
    accel_off_nxt = accel_off_r;
    cnt_nxt       = cnt_a;
    gflag_nxt     = gflag_a;
    aflag_nxt     = aflag_a;
    for (int i = 0; i < AXES; i++) begin
      sum_nxt[i] = sum_r[i];
    end
    if (gflag_a) begin
      if (start) begin
        gyro_off_nxt = '0;
        cnt_nxt      = CNT_FIRST;
        for (int i = 0; i < AXES; i++) sum_nxt[i] = '0;
      end else if (done) begin
        // gyro pass ends; the accel pass opens on this same sample
        gyro_off_nxt  = quot;
        accel_off_nxt = '0;
        cnt_nxt       = CNT_FIRST;
        gflag_nxt     = 1'b0;
        aflag_nxt     = 1'b1;
        for (int i = 0; i < AXES; i++) sum_nxt[i] = '0;
      end else begin
        cnt_nxt = cnt_a + CNT_W'(1);
        for (int i = 0; i < AXES; i++) sum_nxt[i] = sum_add[i];
      end
    end else if (aflag_a) begin
      if (start) begin
        accel_off_nxt = '0;
        cnt_nxt       = CNT_FIRST;
        for (int i = 0; i < AXES; i++) sum_nxt[i] = '0;
      end else if (done) begin
        accel_off_nxt = quot;
        cnt_nxt       = '0;
        aflag_nxt     = 1'b0;
        for (int i = 0; i < AXES; i++) sum_nxt[i] = sum_add[i];
      end else begin
        cnt_nxt = cnt_a + CNT_W'(1);
        for (int i = 0; i < AXES; i++) sum_nxt[i] = sum_add[i];
      end
    end
  end

  // commit state when a request moves to the result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gyro_off_r  <= '0;
      accel_off_r <= '0;
      cnt_r       <= '0;
      gflag_r     <= 1'b0;
      aflag_r     <= 1'b0;
      for (int i = 0; i < AXES; i++) sum_r[i] <= '0;
    end else if (req_i.fire) begin
      gyro_off_r  <= gyro_off_nxt;
      accel_off_r <= accel_off_nxt;
      cnt_r       <= cnt_nxt;
      gflag_r     <= gflag_nxt;
      aflag_r     <= aflag_nxt;
      for (int i = 0; i < AXES; i++) sum_r[i] <= sum_nxt[i];
    end
  end

  assign accel_off_o               = accel_off_r;
  assign gyro_off_o                = gyro_off_r;
  assign status_o.gyro_cal_active  = gflag_nxt;
  assign status_o.accel_cal_active = aflag_nxt;
  assign view_o.gyro_run           = gflag_r;
  assign view_o.accel_run          = aflag_r;
  assign view_o.count_zero         = (cnt_r == '0);
  assign view_o.count_ok           = (cnt_r <= CNT_LAST);

endmodule

// ===== rtl/imu_bias_calibrate_subtract.sv =====
// IMU bias calibrate/subtract top level: input register, calibration unit,
// result register. Uses imu_bcs_pkg, imu_bcs_chan_if and imu_bcs_cal.
// A request waits in the input register until the result register is empty or
// being drained. Throughput: one request per cycle unless out_ch stalls;
// the offset and sum update for a request completes in the cycle it moves from
// the input register to the result register.
// Reset (rst_n low, synchronous): both stages empty, offsets and sums zero,
// no calibration running, accel_one_g back to 8196.
module imu_bias_calibrate_subtract
  import imu_bcs_pkg::*;
#(
  parameter int CAL_SAMPLES = 200
) (
  input  logic           clk,
  input  logic           rst_n,
  imu_bcs_chan_if.sink   in_ch,
  imu_bcs_chan_if.source out_ch,
  imu_bcs_chan_if.sink   cfg_ch
);

  logic [ONE_G_W-1:0] one_g_r;
  logic               s1_v_r;
  in_item_t           s1_r;
  logic               s2_v_r;
  out_item_t          s2_r, s2_nxt;
  logic               adv;
  triad_t             raw_acc, raw_gyr, acc, gyr;
  triad_t             accel_off, gyro_off;
  cal_req_t           cal_req;
  cal_status_t        cal_status;
  cal_view_t          cal_view;

  // hold the config register; the user must write it only while idle (not enforced here)
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      one_g_r <= ONE_G_RESET;
    end else if (cfg_ch.valid) begin
      one_g_r <= cfg_ch.data.accel_one_g;
    end
  end

  // advance when the result register is free or being drained
  assign adv         = s1_v_r && (!s2_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_r <= in_ch.data;
    end
  end

  // subtract stored offsets with word wrap
  always_comb begin
    raw_acc[AX_X] = s1_r.accel_x_raw;
    raw_acc[AX_Y] = s1_r.accel_y_raw;
    raw_acc[AX_Z] = s1_r.accel_z_raw;
    raw_gyr[AX_X] = s1_r.gyro_x_raw;
    raw_gyr[AX_Y] = s1_r.gyro_y_raw;
    raw_gyr[AX_Z] = s1_r.gyro_z_raw;
    for (int i = 0; i < AXES; i++) begin
      acc[i] = raw_acc[i] - accel_off[i];
      gyr[i] = raw_gyr[i] - gyro_off[i];
    end
  end

  assign cal_req.fire  = adv;
  assign cal_req.gyro  = s1_r.request_gyro_cal;
  assign cal_req.accel = s1_r.request_accel_cal;

  imu_bcs_cal #(
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_cal (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_i       (cal_req),
    .acc_i       (acc),
    .gyr_i       (gyr),
    .one_g_i     (one_g_r),
    .accel_off_o (accel_off),
    .gyro_off_o  (gyro_off),
    .status_o    (cal_status),
    .view_o      (cal_view)
  );

  // assemble the result
  always_comb begin
    s2_nxt.accel_x_out      = acc[AX_X];
    s2_nxt.accel_y_out      = acc[AX_Y];
    s2_nxt.accel_z_out      = acc[AX_Z];
    s2_nxt.gyro_x_out       = gyr[AX_X];
    s2_nxt.gyro_y_out       = gyr[AX_Y];
    s2_nxt.gyro_z_out       = gyr[AX_Z];
    s2_nxt.gyro_cal_active  = cal_status.gyro_cal_active;
    s2_nxt.accel_cal_active = cal_status.accel_cal_active;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      s2_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r <= s2_nxt;
    end
  end

  assign out_ch.valid = s2_v_r;
  assign out_ch.data  = s2_r;

  // no pass running means the sample counter is parked at zero
  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    (!cal_view.gyro_run && !cal_view.accel_run) |-> cal_view.count_zero)
    else $error("sample counter nonzero with no calibration running");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cal_view.count_ok)
    else $error("sample counter beyond calibration length");

  // the end of a gyro pass always hands over to an accel pass
  a_gyro_handover: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(cal_view.gyro_run) |-> cal_view.accel_run)
    else $error("gyro calibration ended without starting accel calibration");

  // a free result side never blocks the input side
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_ch.valid || out_ch.ready) |-> in_ch.ready)
    else $error("input stalled while result side is free");

endmodule
